FILE: rtl/bbip_pkg.sv
// shared types and constants of the basic block interval profiler
`default_nettype none

package bbip_pkg;

	localparam int ID_W    = 6;
	localparam int NUM_W   = 7;
	localparam int INC_W   = 16;
	localparam int CYC_W   = 24;
	localparam int EXEC_W  = 32;
	localparam int SUM_W   = 48;
	localparam int CNT_W   = 33;
	localparam int THR_W   = 32;
	localparam int INTV_W  = 32;

	localparam logic [THR_W-1:0] THR_RESET = 32'd100000000;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef struct packed {
		logic [EXEC_W-1:0] exec_count;
		logic [SUM_W-1:0]  cycle_sum;
	} entry_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} tbl_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_SCAN,
		ST_LOAD,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/bbip_table.sv
// per-block count table: one write port, one registered read port, valid bit per entry
`default_nettype none

module bbip_table #(
	parameter int NUM_BLOCKS = 64
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire bbip_pkg::tbl_ctl_t      ctl,
	input  wire logic [$clog2(NUM_BLOCKS)-1:0] rd_addr,
	input  wire logic [$clog2(NUM_BLOCKS)-1:0] wr_addr,
	input  wire bbip_pkg::entry_t        wr_data,
	output bbip_pkg::entry_t             rd_data,
	output logic [NUM_BLOCKS-1:0]        valid
);

	bbip_pkg::entry_t          mem [NUM_BLOCKS];
	bbip_pkg::entry_t          rd_mem_q;
	logic                      rd_valid_q;
	logic [NUM_BLOCKS-1:0]     valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_mem_q <= mem[rd_addr];
		end
	end

	// an entry that was never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_mem_q : '0;
	assign valid   = valid_q;

endmodule

`default_nettype wire

FILE: rtl/basic_block_interval_profiler.sv
// record item: table read at accept, saturating update and write back in the next cycle
// a dump scans ids up to the highest in use (all when empty) one a cycle, stopping in a load
// state for each beat until the output is free, and ends in a state that clears the table
// first result of a dump: read at its id in the scan state, registered out in the load state; no input meanwhile
// reset (async, active low) empties the table via its valid bits, zeroes the counters
// and loads the threshold with 100000000; no clearing pass is needed
`default_nettype none

module basic_block_interval_profiler #(
	parameter int NUM_BLOCKS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] interval_threshold,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [5:0]  block_id,
	input  wire logic [15:0] insn_inc,
	input  wire logic [23:0] block_cycles,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [6:0]       block_number,
	output logic [31:0]      exec_count,
	output logic [47:0]      cycle_sum,
	output logic [31:0]      interval_index,
	output logic [5:0]       start_block,
	output logic             last
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);

	bbip_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0]              idx_q;
	logic [IDX_W-1:0]              addr_q;
	logic [bbip_pkg::INC_W-1:0]    inc_q;
	logic [bbip_pkg::CYC_W-1:0]    cyc_q;
	logic [bbip_pkg::CNT_W-1:0]    cnt_q;
	logic [bbip_pkg::THR_W-1:0]    thr_q;
	logic [bbip_pkg::ID_W-1:0]     start_q;
	logic [bbip_pkg::INTV_W-1:0]   intv_q;
	logic                          adv_q;

	logic                          out_valid_q;
	logic [bbip_pkg::NUM_W-1:0]    num_q;
	logic [bbip_pkg::EXEC_W-1:0]   exec_q;
	logic [bbip_pkg::SUM_W-1:0]    sum_q;
	logic [bbip_pkg::INTV_W-1:0]   oint_q;
	logic [bbip_pkg::ID_W-1:0]     ostart_q;
	logic                          last_q;

	bbip_pkg::tbl_ctl_t            tbl_ctl;
	logic [IDX_W-1:0]              tbl_rd_addr;
	bbip_pkg::entry_t              tbl_wr_data;
	bbip_pkg::entry_t              cur;
	logic [NUM_BLOCKS-1:0]         tbl_valid;
	logic [NUM_BLOCKS-1:0]         above;

	logic                          in_beat;
	logic                          id_ok;
	logic                          is_flush;
	logic                          out_free;
	logic                          load_out;
	logic                          scan_end;
	logic                          last_sel;
	logic                          hit;
	logic [bbip_pkg::CNT_W:0]      cnt_sum;
	logic [bbip_pkg::CNT_W-1:0]    cnt_new;
	logic [bbip_pkg::SUM_W:0]      cyc_sum;

	bbip_table #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.rd_addr (tbl_rd_addr),
		.wr_addr (addr_q),
		.wr_data (tbl_wr_data),
		.rd_data (cur),
		.valid   (tbl_valid)
	);

	assign in_beat  = in_valid && in_ready;
	assign id_ok    = {1'b0, block_id} < bbip_pkg::NUM_W'(NUM_BLOCKS);
	assign is_flush = (op == bbip_pkg::OP_FLUSH);
	assign out_free = !out_valid_q || out_ready;
	assign scan_end = (idx_q == IDX_W'(NUM_BLOCKS - 1));

	// saturating read-modify-write of one entry
	always_comb begin
		cnt_sum = {1'b0, cnt_q} + (bbip_pkg::CNT_W + 1)'(inc_q);
		cnt_new = cnt_sum[bbip_pkg::CNT_W] ? '1 : cnt_sum[bbip_pkg::CNT_W-1:0];
		cyc_sum = {1'b0, cur.cycle_sum} + (bbip_pkg::SUM_W + 1)'(cyc_q);
		tbl_wr_data.exec_count = (&cur.exec_count) ? cur.exec_count
		                                           : cur.exec_count + 32'd1;
		tbl_wr_data.cycle_sum  = cyc_sum[bbip_pkg::SUM_W] ? '1
		                                                  : cyc_sum[bbip_pkg::SUM_W-1:0];
		hit = (cnt_new >= {1'b0, thr_q});
	end

	// used entries always hold a nonzero count, so the valid bits mark what gets dumped
	always_comb begin
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			above[i] = tbl_valid[i] && (IDX_W'(i) > idx_q);
		end
		last_sel = ~|above;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bbip_pkg::ST_IDLE: begin
				if (in_beat) begin
					if (is_flush) begin
						state_d = bbip_pkg::ST_SCAN;
					end else if (id_ok) begin
						state_d = bbip_pkg::ST_UPD;
					end
				end
			end
			bbip_pkg::ST_UPD: begin
				state_d = hit ? bbip_pkg::ST_SCAN : bbip_pkg::ST_IDLE;
			end
			bbip_pkg::ST_SCAN: begin
				if (tbl_valid[idx_q]) begin
					state_d = bbip_pkg::ST_LOAD;
				end else if (scan_end) begin
					state_d = bbip_pkg::ST_DONE;
				end
			end
			bbip_pkg::ST_LOAD: begin
				if (out_free) begin
					state_d = last_sel ? bbip_pkg::ST_DONE : bbip_pkg::ST_SCAN;
				end
			end
			bbip_pkg::ST_DONE: begin
				state_d = bbip_pkg::ST_IDLE;
			end
			default: begin
				state_d = bbip_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready      = 1'b0;
		tbl_ctl       = '0;
		tbl_rd_addr   = idx_q;
		load_out      = 1'b0;
		unique case (state_q)
			bbip_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				tbl_ctl.rd_en = in_valid;
				tbl_rd_addr   = block_id[IDX_W-1:0];
			end
			bbip_pkg::ST_UPD: begin
				tbl_ctl.wr_en = 1'b1;
			end
			bbip_pkg::ST_SCAN: begin
				tbl_ctl.rd_en = 1'b1;
			end
			bbip_pkg::ST_LOAD: begin
				load_out = out_free;
			end
			bbip_pkg::ST_DONE: begin
				tbl_ctl.clr = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bbip_pkg::ST_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			thr_q       <= bbip_pkg::THR_RESET;
			start_q     <= '0;
			intv_q      <= '0;
			adv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				thr_q <= interval_threshold;
			end
			unique case (state_q)
				bbip_pkg::ST_IDLE: begin
					idx_q <= '0;
					adv_q <= 1'b0;
					if (in_beat && !is_flush && id_ok && (cnt_q == '0)) begin
						start_q <= block_id;
					end
				end
				bbip_pkg::ST_UPD: begin
					cnt_q <= cnt_new;
					adv_q <= hit;
				end
				bbip_pkg::ST_SCAN: begin
					if (!tbl_valid[idx_q] && !scan_end) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				bbip_pkg::ST_LOAD: begin
					if (out_free && !last_sel) begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				bbip_pkg::ST_DONE: begin
					cnt_q <= '0;
					if (adv_q) begin
						intv_q <= intv_q + 32'd1;
					end
				end
				default: begin
					idx_q <= '0;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			addr_q <= block_id[IDX_W-1:0];
			inc_q  <= insn_inc;
			cyc_q  <= block_cycles;
		end
		if (load_out) begin
			num_q    <= bbip_pkg::NUM_W'(idx_q) + 7'd1;
			exec_q   <= cur.exec_count;
			sum_q    <= cur.cycle_sum;
			oint_q   <= intv_q;
			ostart_q <= start_q;
			last_q   <= last_sel;
		end
	end

	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign block_number   = num_q;
	assign exec_count     = exec_q;
	assign cycle_sum      = sum_q;
	assign interval_index = oint_q;
	assign start_block    = ostart_q;
	assign last           = last_q;

	a_record_updates: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && !is_flush && id_ok) |=> (state_q == bbip_pkg::ST_UPD))
		else $error("accepted record did not go to update");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbip_pkg::ST_UPD) |=> tbl_valid[$past(addr_q)])
		else $error("written entry not marked in use");

	a_dump_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bbip_pkg::ST_DONE) |=> ((tbl_valid == '0) && (cnt_q == '0)))
		else $error("table or counter not cleared after dump");

	a_beat_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == bbip_pkg::ST_LOAD))
		else $error("result beat raised outside table walk");

endmodule

`default_nettype wire

FILE: test/basic_block_interval_profiler_tb.sv
// self-checking testbench for the basic block interval profiler
`timescale 1ns / 100ps

module basic_block_interval_profiler_tb;

	localparam int NBLK         = 64;
	localparam int RESET_CYCLES = 11;
	// an empty flush still walks the whole table before the block is idle again
	localparam int QUIET_CYCLES = NBLK + 16;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		logic [bbip_pkg::NUM_W-1:0]  number;
		logic [bbip_pkg::EXEC_W-1:0] count;
		logic [bbip_pkg::SUM_W-1:0]  sum;
		logic [bbip_pkg::INTV_W-1:0] index;
		logic [bbip_pkg::ID_W-1:0]   start;
		logic                        is_last;
	} dump_beat_t;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [bbip_pkg::THR_W-1:0]  interval_threshold;
	logic                        in_valid;
	logic                        in_ready;
	logic                        op;
	logic [bbip_pkg::ID_W-1:0]   block_id;
	logic [bbip_pkg::INC_W-1:0]  insn_inc;
	logic [bbip_pkg::CYC_W-1:0]  block_cycles;
	logic                        out_valid;
	logic                        out_ready;
	logic [bbip_pkg::NUM_W-1:0]  block_number;
	logic [bbip_pkg::EXEC_W-1:0] exec_count;
	logic [bbip_pkg::SUM_W-1:0]  cycle_sum;
	logic [bbip_pkg::INTV_W-1:0] interval_index;
	logic [bbip_pkg::ID_W-1:0]   start_block;
	logic                        last;

	// predictor state
	logic [bbip_pkg::THR_W-1:0]  thr_shadow;
	logic [bbip_pkg::CNT_W-1:0]  insn_total;
	logic [bbip_pkg::EXEC_W-1:0] exec_tbl [NBLK];
	logic [bbip_pkg::SUM_W-1:0]  cyc_tbl [NBLK];
	logic [bbip_pkg::INTV_W-1:0] interval_no;
	logic [bbip_pkg::ID_W-1:0]   start_id;

	dump_beat_t dump_queue [$];
	dump_beat_t exp_beat;

	int err_count;
	int beats_seen;
	int items_sent;
	int dumps_seen;
	int cfg_writes;
	int idle_pct;
	int stall_pct;
	int cycle_count;

	basic_block_interval_profiler #(
		.NUM_BLOCKS(NBLK)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.interval_threshold(interval_threshold),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.block_id(block_id),
		.insn_inc(insn_inc),
		.block_cycles(block_cycles),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.block_number(block_number),
		.exec_count(exec_count),
		.cycle_sum(cycle_sum),
		.interval_index(interval_index),
		.start_block(start_block),
		.last(last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (dump_queue.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual block_number %0d",
					$time, block_number);
				err_count++;
			end else begin
				exp_beat = dump_queue.pop_front();
				check_field("block_number", 48'(exp_beat.number), 48'(block_number));
				check_field("exec_count", 48'(exp_beat.count), 48'(exec_count));
				check_field("cycle_sum", exp_beat.sum, cycle_sum);
				check_field("interval_index", 48'(exp_beat.index), 48'(interval_index));
				check_field("start_block", 48'(exp_beat.start), 48'(start_block));
				check_field("last", 48'(exp_beat.is_last), 48'(last));
			end
		end
	end

	// queue one beat per used entry in id order, then empty the table
	task automatic dump_profile_table();
		int last_id;
		dump_beat_t beat;
		last_id = -1;
		for (int i = 0; i < NBLK; i++)
			if (exec_tbl[i] != '0)
				last_id = i;
		if (last_id >= 0)
			dumps_seen++;
		for (int i = 0; i < NBLK; i++) begin
			if (exec_tbl[i] != '0) begin
				beat.number  = bbip_pkg::NUM_W'(i + 1);
				beat.count   = exec_tbl[i];
				beat.sum     = cyc_tbl[i];
				beat.index   = interval_no;
				beat.start   = start_id;
				beat.is_last = (i == last_id);
				dump_queue = {dump_queue, beat};
			end
			exec_tbl[i] = '0;
			cyc_tbl[i]  = '0;
		end
		insn_total = '0;
	endtask

	task automatic predict_profile(logic opv, logic [bbip_pkg::ID_W-1:0] id,
		logic [bbip_pkg::INC_W-1:0] inc, logic [bbip_pkg::CYC_W-1:0] cyc);
		logic [bbip_pkg::CNT_W:0] insn_next;
		logic [bbip_pkg::SUM_W:0] sum_next;
		items_sent++;
		if (opv == bbip_pkg::OP_FLUSH) begin
			dump_profile_table();
		end else if (id < NBLK) begin
			if (insn_total == '0)
				start_id = id;
			insn_next  = {1'b0, insn_total} + (bbip_pkg::CNT_W + 1)'(inc);
			insn_total = insn_next[bbip_pkg::CNT_W] ? '1 : insn_next[bbip_pkg::CNT_W-1:0];
			if (exec_tbl[id] != '1)
				exec_tbl[id] = exec_tbl[id] + bbip_pkg::EXEC_W'(1);
			sum_next    = {1'b0, cyc_tbl[id]} + (bbip_pkg::SUM_W + 1)'(cyc);
			cyc_tbl[id] = sum_next[bbip_pkg::SUM_W] ? '1 : sum_next[bbip_pkg::SUM_W-1:0];
			if (insn_total >= {1'b0, thr_shadow}) begin
				dump_profile_table();
				interval_no = interval_no + bbip_pkg::INTV_W'(1);
			end
		end
	endtask

	task automatic reset_predictor();
		thr_shadow  = bbip_pkg::THR_RESET;
		insn_total  = '0;
		interval_no = '0;
		start_id    = '0;
		for (int i = 0; i < NBLK; i++) begin
			exec_tbl[i] = '0;
			cyc_tbl[i]  = '0;
		end
	endtask

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic send_item(logic opv, logic [bbip_pkg::ID_W-1:0] id,
		logic [bbip_pkg::INC_W-1:0] inc, logic [bbip_pkg::CYC_W-1:0] cyc);
		while ($urandom_range(99) < idle_pct) begin
			in_valid     = 1'b0;
			op           = 1'($urandom);
			block_id     = bbip_pkg::ID_W'($urandom);
			insn_inc     = bbip_pkg::INC_W'($urandom);
			block_cycles = bbip_pkg::CYC_W'($urandom);
			@(negedge clk);
		end
		in_valid     = 1'b1;
		op           = opv;
		block_id     = id;
		insn_inc     = inc;
		block_cycles = cyc;
		do @(posedge clk); while (!in_ready);
		predict_profile(opv, id, inc, cyc);
		@(negedge clk);
	endtask

	task automatic wait_quiet();
		in_valid = 1'b0;
		while (dump_queue.size() != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(logic [bbip_pkg::THR_W-1:0] value);
		wait_quiet();
		cfg_valid          = 1'b1;
		interval_threshold = value;
		do @(posedge clk); while (!cfg_ready);
		thr_shadow = value;
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// reset threshold is far away, so only flushes close the interval
	task automatic test_reset_threshold();
		send_item(bbip_pkg::OP_FLUSH, 6'd0, 16'd0, 24'd0);
		send_item(bbip_pkg::OP_RECORD, 6'd0, 16'hFFFF, 24'hFFFFFF);
		send_item(bbip_pkg::OP_RECORD, 6'd63, 16'd0, 24'd0);
		send_item(bbip_pkg::OP_RECORD, 6'd0, 16'd1, 24'd1);
		send_item(bbip_pkg::OP_FLUSH, 6'd63, 16'hFFFF, 24'hFFFFFF);
	endtask

	// zero-length records keep the counter at zero and move the start block
	task automatic test_start_block();
		write_threshold(32'd1);
		send_item(bbip_pkg::OP_RECORD, 6'd10, 16'd0, 24'd5);
		send_item(bbip_pkg::OP_RECORD, 6'd20, 16'd0, 24'd7);
		send_item(bbip_pkg::OP_RECORD, 6'd30, 16'd1, 24'd9);
		send_item(bbip_pkg::OP_RECORD, 6'd42, 16'd2, 24'hABCDEF);
	endtask

	// a lowered threshold makes the next record dump, then an empty flush
	task automatic test_threshold_lowered();
		write_threshold(32'hFFFFFFFF);
		send_item(bbip_pkg::OP_RECORD, 6'd1, 16'hFFFF, 24'h123456);
		send_item(bbip_pkg::OP_RECORD, 6'd62, 16'hFFFF, 24'hFFFFFF);
		send_item(bbip_pkg::OP_RECORD, 6'd1, 16'hFFFF, 24'hFFFFFF);
		send_item(bbip_pkg::OP_RECORD, 6'd31, 16'h8000, 24'h000001);
		write_threshold(32'd1000);
		send_item(bbip_pkg::OP_RECORD, 6'd33, 16'd0, 24'd3);
		send_item(bbip_pkg::OP_FLUSH, 6'd5, 16'd5, 24'd5);
		send_item(bbip_pkg::OP_RECORD, 6'd2, 16'd999, 24'd4);
		send_item(bbip_pkg::OP_RECORD, 6'd2, 16'd1, 24'd4);
	endtask

	task automatic test_random_intervals(int count, logic [bbip_pkg::THR_W-1:0] thr);
		logic                       opv;
		logic [bbip_pkg::ID_W-1:0]  id;
		logic [bbip_pkg::INC_W-1:0] inc;
		logic [bbip_pkg::CYC_W-1:0] cyc;
		logic [bbip_pkg::ID_W-1:0]  hot_base;
		write_threshold(thr);
		hot_base = bbip_pkg::ID_W'($urandom);
		for (int n = 0; n < count; n++) begin
			opv = ($urandom_range(99) < 5) ? bbip_pkg::OP_FLUSH : bbip_pkg::OP_RECORD;
			// mostly a few hot blocks so entries repeat within an interval
			id = ($urandom_range(3) == 0) ? bbip_pkg::ID_W'($urandom)
			                              : hot_base + bbip_pkg::ID_W'($urandom_range(3));
			case ($urandom_range(9))
				0: inc = '0;
				1: inc = '1;
				2: inc = bbip_pkg::INC_W'($urandom_range(15));
				default: inc = bbip_pkg::INC_W'($urandom);
			endcase
			case ($urandom_range(7))
				0: cyc = '0;
				1: cyc = '1;
				default: cyc = bbip_pkg::CYC_W'($urandom);
			endcase
			send_item(opv, id, inc, cyc);
			if ($urandom_range(19) == 0) begin
				// hold off until every queued beat has drained
				in_valid = 1'b0;
				while (dump_queue.size() != 0)
					@(negedge clk);
			end
		end
	endtask

	task automatic test_random_phase(int idle, int stall);
		idle_pct  = idle;
		stall_pct = stall;
		test_random_intervals(32, $urandom_range(200000, 40000));
		test_random_intervals(32, ($urandom_range(1) == 0) ? 32'd1 : $urandom_range(65535, 1));
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_valid          = 1'b0;
		interval_threshold = '0;
		in_valid           = 1'b0;
		op                 = bbip_pkg::OP_RECORD;
		block_id           = '0;
		insn_inc           = '0;
		block_cycles       = '0;
		out_ready          = 1'b0;
		err_count          = 0;
		beats_seen         = 0;
		items_sent         = 0;
		dumps_seen         = 0;
		cfg_writes         = 0;
		idle_pct           = 0;
		stall_pct          = 0;
		cycle_count        = 0;
		reset_predictor();
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_threshold();
		test_start_block();
		test_threshold_lowered();
		test_random_phase(0, 0);
		test_random_phase(67, 0);
		test_random_phase(0, 67);
		test_random_phase(6, 6);
		idle_pct = 0;
		send_item(bbip_pkg::OP_FLUSH, 6'd0, 16'd0, 24'd0);

		wait_quiet();
		$display("sent %0d record and flush beats over %0d threshold writes", items_sent,
			cfg_writes);
		$display("checked %0d result beats from %0d table dumps, %0d errors", beats_seen,
			dumps_seen, err_count);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
